FILE: hdl/assert_macros.svh
// shared assertion macros for the moving average checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, masked while reset is high
`define MAF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on the rising edge, live through reset as well
`define MAF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/maf_pkg.sv
package maf_pkg;

  // width and reset value of the window length register
  localparam int WIN_LEN_W     = 9;
  localparam int WIN_LEN_RESET = 4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUB  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } maf_state_t;

endpackage

FILE: hdl/maf_ram.sv
module maf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/maf_divider.sv
module maf_divider #(
  parameter int SUM_W = 41,
  parameter int DIV_W = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [DIV_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic              neg;
  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DIV_W:0]    trial;
  logic              fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        neg   <= dividend[SUM_W-1];
        quo   <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        rem   <= '0;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        if (steps != '0) begin
          rem   <= fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
          quo   <= {quo[SUM_W-2:0], fits};
          steps <= steps - STEP_W'(1);
        end else begin
          // sign fix, truncation toward zero
          quotient <= neg ? -$signed(quo) : $signed(quo);
          done     <= 1'b1;
          busy     <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/moving_average_filter_top.sv
// Boxcar moving average. Each accepted sample beat enters a circular delay line
// of window_len slots and updates a running window sum (new sample in, oldest
// sample out). Once the series holds window_len samples, every sample beat
// yields one average beat: window sum / window_len, truncated toward zero.
// series_start clears the series before its sample is taken; writing
// window_len in the idle state also clears the series, and a window write
// holds the sample side off for that cycle. window_len of 0 acts as 1,
// above WINDOW_MAX as WINDOW_MAX. An accepted sample goes to a subtract state
// that drops the oldest sample and stores the new one; once the window is
// full, the bit-serial restoring divider then resolves one quotient bit per
// cycle over the SUM_W-bit sum. A finished average that meets a stalled,
// occupied output register waits in the divider, the sample side held off.
// The delay line sits in a single-port-write, registered-read RAM; slots are
// only read once written in the current series, so it needs no clearing
// after reset. Once an average is in the output register, the next sample
// is taken while it is pending.
module moving_average_filter_top
  import maf_pkg::*;
#(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          series_start,
  // average channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average,
  // window length register
  input  logic                          cfg_wr_en,
  input  logic [WIN_LEN_W-1:0]          cfg_wr_data
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  // sum of up to WINDOW_MAX samples plus a spare sign bit
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;

  // effective window: zero acts as one, capped at the delay line depth
  function automatic logic [CNT_W-1:0] clamp_win(input logic [WIN_LEN_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (int'(v) > WINDOW_MAX) begin
      return CNT_W'(WINDOW_MAX);
    end
    return CNT_W'(v);
  endfunction

  maf_state_t                 state;
  logic [CNT_W-1:0]           win;
  logic [CNT_W-1:0]           fill;
  logic [PTR_W-1:0]           ptr;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic                       div_start;

  logic                       in_fire;
  logic                       out_free;
  logic                       out_load;
  logic [PTR_W-1:0]           rd_addr;
  logic [SAMPLE_BITS-1:0]     old_samp;
  logic                       ram_we;
  logic [CNT_W-1:0]           fill_next;
  logic [CNT_W-1:0]           ptr_inc;
  logic                       div_done;
  logic signed [SUM_W-1:0]    quotient;

  // a window write takes the idle cycle, the sample waits for the next one
  assign in_stall = (state != S_IDLE) || cfg_wr_en;
  assign in_fire  = in_valid && !in_stall;
  // output register can take a new average this cycle
  assign out_free = !out_valid || !out_stall;
  // finished quotient moves into the output register
  assign out_load = out_free && (((state == S_DIV) && div_done) || (state == S_HOLD));

  // the slot about to be overwritten is read in the accept cycle
  assign rd_addr   = (in_fire && series_start) ? '0 : ptr;
  assign ram_we    = (state == S_SUB);
  assign fill_next = (fill < win) ? fill + CNT_W'(1) : fill;
  assign ptr_inc   = CNT_W'(ptr) + CNT_W'(1);

  maf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_delay (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ptr),
    .wr_data (samp),
    .rd_addr (rd_addr),
    .rd_data (old_samp)
  );

  maf_divider #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (win),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      win       <= clamp_win(WIN_LEN_W'(WIN_LEN_RESET));
      fill      <= '0;
      ptr       <= '0;
      sum       <= '0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // divide starts once the window is full after this sample
      div_start <= (state == S_SUB) && (fill_next >= win);
      // a waiting beat leaves, or a new average replaces it in the same cycle
      if (out_load) begin
        average   <= quotient[SAMPLE_BITS-1:0];
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cfg_wr_en) begin
            // new window abandons the current series
            win  <= clamp_win(cfg_wr_data);
            fill <= '0;
            ptr  <= '0;
            sum  <= '0;
          end else if (in_fire) begin
            samp <= sample;
            sum  <= (series_start ? SUM_W'(0) : sum) + SUM_W'(sample);
            if (series_start) begin
              fill <= '0;
              ptr  <= '0;
            end
            state <= S_SUB;
          end
        end
        S_SUB: begin
          // drop the sample leaving a full window, store the new one
          if (fill >= win) begin
            sum <= sum - SUM_W'($signed(old_samp));
          end
          fill <= fill_next;
          ptr  <= (ptr_inc >= win) ? '0 : PTR_W'(ptr_inc);
          if (fill_next >= win) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          // quotient stays put in the divider until its next start
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/maf_checker.sv
`include "assert_macros.svh"

module maf_checker
  import maf_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          series_start,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] average,
  input logic                          cfg_wr_en,
  input logic [WIN_LEN_W-1:0]          cfg_wr_data
);

  // a stalled average beat stays on the port unchanged
  `MAF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(average), "average beat changed while stalled")

  // one sample at a time: the block is busy right after taking a beat
  `MAF_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall, "sample taken while previous still in work")

  // an average appears only from work in progress, never in the cycle after a take
  `MAF_ASSERT(a_no_instant_avg, in_valid && !in_stall |=> !$rose(out_valid), "average raised straight after a sample")

  // a new average beat only comes while the sample side is held off
  `MAF_ASSERT(a_avg_from_busy, $rose(out_valid) |-> $past(in_stall), "average raised while the block was idle")

  // reset empties the output register
  `MAF_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "average valid right after reset")

endmodule

bind moving_average_filter_top maf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_maf_checker (.*);

FILE: sim/tb_moving_average_filter_top.sv
module tb_moving_average_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import maf_pkg::*;

  // window bound and sample extremes at the default build
  localparam int WIN_MAX = 256;
  localparam logic signed [31:0] SMP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMP_MIN = 32'sh8000_0000;

  // wait after the last owed average, long enough for any beat still in flight
  localparam int SETTLE_CYCLES = 60;
  // cycles with no beat on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // sample channel
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] sample = '0;
  logic series_start = 1'b0;

  // average channel
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] average;

  // window length register
  logic cfg_wr_en = 1'b0;
  logic [WIN_LEN_W-1:0] cfg_wr_data = '0;

  // idle rates in percent, changed between phases
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // predictor state: delay line, running sum, fill count, write slot and window register
  logic signed [31:0] taps [WIN_MAX];
  logic signed [39:0] win_sum = '0;
  int unsigned fill_cnt = 0;
  int unsigned wr_ptr = 0;
  logic [WIN_LEN_W-1:0] win_len_reg = WIN_LEN_W'(WIN_LEN_RESET);

  // averages still owed by the block, oldest first
  logic signed [31:0] pending_avgs [$];

  int fail_count = 0;
  int quiet_cycles = 0;

  moving_average_filter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .series_start (series_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average      (average),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // register value to window length actually used: 0 acts as 1, clamp at the top
  function automatic int unsigned span_of(logic [WIN_LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > WIN_MAX) return WIN_MAX;
    return len;
  endfunction

  function automatic void clear_series();
    win_sum = '0;
    fill_cnt = 0;
    wr_ptr = 0;
  endfunction

  // one accepted sample beat: update the window and queue the average it yields, if any
  function automatic void predict_average(logic signed [31:0] smp, logic first);
    int unsigned w;
    longint quot;
    w = span_of(win_len_reg);
    if (first) clear_series();
    if (wr_ptr >= w) wr_ptr = 0;
    // oldest sample drops out only once the window is full
    if (fill_cnt >= w) win_sum -= taps[wr_ptr];
    win_sum += smp;
    taps[wr_ptr] = smp;
    wr_ptr = (wr_ptr + 1 >= w) ? 0 : wr_ptr + 1;
    if (fill_cnt < w) fill_cnt++;
    if (fill_cnt >= w) begin
      // signed division truncates toward zero, as the block must
      quot = longint'(win_sum) / longint'(w);
      pending_avgs.push_back(quot[31:0]);
    end
  endfunction

  function automatic void flag_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", what);
  endfunction

  // ---------------------------------------------------------------------------
  // checking and watchdog
  // ---------------------------------------------------------------------------

  // every accepted average beat is matched against the oldest owed average
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_avgs.size() == 0) begin
        flag_failure($sformatf("average beat with none owed: expected nothing, got %0d",
                               average));
      end else begin
        want = pending_avgs.pop_front();
        if (average !== want)
          flag_failure($sformatf("average mismatch: expected %0d, got %0d", want, average));
      end
    end
  end

  // counts cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  // drives one sample beat, with random gaps ahead of it, and returns at its acceptance
  task automatic send_sample(input logic signed [31:0] smp, input logic first);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= smp;
    series_start <= first;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_average(smp, first);
  endtask

  // drops valid, waits for every owed average, then lets a sample with no result finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write while the block is idle; the write also abandons the series
  task automatic set_window(input logic [WIN_LEN_W-1:0] len);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    win_len_reg = len;
    clear_series();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly full-range values, with extremes and small values around zero mixed in
  function automatic logic signed [31:0] random_sample();
    case ($urandom_range(9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2, 3: return $signed($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset window of 4, one series from reset with no start flag
  task automatic test_reset_window();
    send_sample(4, 1'b0);
    send_sample(8, 1'b0);
    send_sample(12, 1'b0);
    send_sample(16, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MIN, 1'b0);
  endtask

  // negative sums must truncate toward zero, not floor
  task automatic test_truncation();
    set_window(9'd3);
    send_sample(-1, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(7, 1'b0);
    // window of one passes samples straight through
    set_window(9'd1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-3, 1'b0);
  endtask

  // short series give nothing; a start flag mid-window restarts the fill
  task automatic test_series_start();
    set_window(9'd3);
    send_sample(10, 1'b1);
    send_sample(20, 1'b0);
    send_sample(30, 1'b1);
    send_sample(40, 1'b0);
    send_sample(1, 1'b1);
    send_sample(2, 1'b0);
    send_sample(3, 1'b0);
    send_sample(4, 1'b0);
    send_sample(100, 1'b1);
    send_sample(200, 1'b0);
    send_sample(300, 1'b0);
  endtask

  // window of 0 acts as 1, 256 is the top
  task automatic test_window_clamp();
    set_window(9'd0);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    // full window of extremes: widest positive and negative window sums
    set_window(9'd256);
    repeat (WIN_MAX) send_sample(SMP_MAX, 1'b0);
    repeat (WIN_MAX) send_sample(SMP_MIN, 1'b0);
  endtask

  // rewriting the same length still throws the current series away
  task automatic test_config_abandons();
    set_window(9'd4);
    send_sample(10, 1'b0);
    send_sample(20, 1'b0);
    send_sample(30, 1'b0);
    send_sample(40, 1'b0);
    send_sample(50, 1'b0);
    set_window(9'd4);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    send_sample(3, 1'b0);
    send_sample(5, 1'b0);
  endtask

  // series of random content in one window setting; most run past the fill, some stop short
  task automatic run_series(input logic [WIN_LEN_W-1:0] len, input int n_items);
    int unsigned w;
    int left;
    logic first;
    set_window(len);
    w = span_of(len);
    // the write already cleared the series, so the first flag is optional here
    left = w + $urandom_range(3 * w);
    first = 1'($urandom_range(1));
    repeat (n_items) begin
      if (left == 0) begin
        first = 1'b1;
        if (w > 1 && $urandom_range(99) < 15) left = $urandom_range(w - 1, 1);
        else left = w + $urandom_range(3 * w);
      end else if ($urandom_range(99) < 2) begin
        // stray restart inside a series
        first = 1'b1;
      end
      send_sample(random_sample(), first);
      first = 1'b0;
      left--;
    end
  endtask

  // random windows, mostly small, including the 0 and 1 corners
  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_items);
    int left;
    int chunk;
    logic [WIN_LEN_W-1:0] len;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(9))
        0: len = 9'd0;
        1: len = 9'd1;
        7, 8: len = WIN_LEN_W'($urandom_range(48, 9));
        default: len = WIN_LEN_W'($urandom_range(8, 2));
      endcase
      chunk = $urandom_range(120, 40);
      if (chunk > left) chunk = left;
      run_series(len, chunk);
      left -= chunk;
    end
  endtask

  // window above the top acts as 256, random content drives the upper register bits
  task automatic test_full_window_random();
    run_series(WIN_LEN_W'($urandom_range(511, 257)), 200);
  endtask

  initial begin
    foreach (taps[i]) taps[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    send_gap_pct = 20;
    recv_stall_pct = 62;
    test_reset_window();
    test_truncation();
    test_series_start();
    test_window_clamp();
    test_config_abandons();
    test_random_traffic(20, 62, 100);
    // roles swapped, then free-running
    test_random_traffic(62, 20, 100);
    test_random_traffic(0, 0, 100);
    test_full_window_random();

    settle();
    if (fail_count == 0 && pending_avgs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
